// ----- hdl/cpr_pkg.sv -----
// Shared types and constants for the circle point rasterizer.
// Holds field widths, control word layout and the microcode program.
// No dependencies.
`default_nettype none

package cpr_pkg;

	localparam int CX_W  = 11;  // center coordinate width
	localparam int RAD_W = 6;   // radius field width
	localparam int PT_W  = 12;  // output coordinate width
	localparam int DX_W  = 6;   // horizontal offset
	localparam int DY_W  = 7;   // vertical offset, signed
	localparam int D_W   = 10;  // error term, signed
	localparam int E_W   = 12;  // working width for the decision math
	localparam int CNT_W = 6;   // run counter
	localparam logic [CNT_W-1:0] RUN_LAST = CNT_W'(63);

	// Program addresses
	typedef enum logic [0:0] {
		STEP_IDLE = 1'b0,
		STEP_WALK = 1'b1
	} step_t;

	// Jump conditions; when not met the sequencer stays on its step
	typedef enum logic [1:0] {
		COND_HOLD      = 2'd0,
		COND_IN_XFER   = 2'd1,
		COND_LAST_EMIT = 2'd2
	} cond_t;

	typedef struct packed {
		logic  accept;  // open the request channel, load walk on transfer
		logic  emit;    // produce one point group per output slot
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		logic accept;
		logic emit;
	} ctrl_t;

	typedef struct packed {
		logic in_xfer;
		logic emit_fire;
		logic last;
	} status_t;

	localparam int PROG_LEN = 2;

	localparam ctrl_word_t PROGRAM [PROG_LEN] = '{
		'{accept: 1'b1, emit: 1'b0, cond: COND_IN_XFER,   target: STEP_WALK},
		'{accept: 1'b0, emit: 1'b1, cond: COND_LAST_EMIT, target: STEP_IDLE}
	};

endpackage

`default_nettype wire

// ----- hdl/cpr_channels.sv -----
// Valid/ready channel interfaces: circle requests and point groups.
// Depends on cpr_pkg for field widths.
`default_nettype none

interface cpr_req_if;
	logic                              valid;
	logic                              ready;
	logic signed [cpr_pkg::CX_W-1:0]   center_x;
	logic signed [cpr_pkg::CX_W-1:0]   center_y;
	logic        [cpr_pkg::RAD_W-1:0]  radius;

	modport source (output valid, output center_x, output center_y, output radius,
		input ready);
	modport sink (input valid, input center_x, input center_y, input radius,
		output ready);
endinterface

interface cpr_pt_if;
	logic                            valid;
	logic                            ready;
	logic signed [cpr_pkg::PT_W-1:0] right_x;
	logic signed [cpr_pkg::PT_W-1:0] left_x;
	logic signed [cpr_pkg::PT_W-1:0] top_y;
	logic signed [cpr_pkg::PT_W-1:0] bottom_y;
	logic                            last_step;

	modport source (output valid, output right_x, output left_x, output top_y,
		output bottom_y, output last_step, input ready);
	modport sink (input valid, input right_x, input left_x, input top_y,
		input bottom_y, input last_step, output ready);
endinterface

`default_nettype wire

// ----- hdl/circle_point_rasterizer.sv -----
// Top level of the midpoint circle outline rasterizer.
// Depends on cpr_pkg, cpr_channels.sv, cpr_sequencer and cpr_datapath.
//
//   channel | dir | payload                                        | per request
//   req     | in  | center_x, center_y, radius                     | one transfer
//   pt      | out | right_x, left_x, top_y, bottom_y, last_step    | one per step
//
// One point group per cycle while the walk runs and pt is not stalled; a request
// is loaded in the idle step and then gives one group per walk step (47 groups
// at radius 32), from the single-step walk loop of the microcode. The next
// request is taken while the final group still sits in the output register.
// Reset clears the step counter and the output valid flag.
// A stalled pt channel holds the walk on its step; nothing is dropped.
`default_nettype none

module circle_point_rasterizer #(
	parameter int MAX_RADIUS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cpr_req_if.sink   req,
	cpr_pt_if.source  pt
);

	cpr_pkg::ctrl_t   ctrl;
	cpr_pkg::status_t status;

	cpr_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	cpr_datapath #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.status (status),
		.req    (req),
		.pt     (pt)
	);

endmodule

`default_nettype wire

// ----- hdl/cpr_sequencer.sv -----
// Microcode sequencer: step counter over the program table in cpr_pkg.
// Depends on cpr_pkg; takes datapath status, drives datapath control.
`default_nettype none

module cpr_sequencer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cpr_pkg::status_t status,
	output cpr_pkg::ctrl_t        ctrl
);

	cpr_pkg::step_t      pc_q;
	cpr_pkg::step_t      pc_d;
	cpr_pkg::ctrl_word_t cw;
	logic                jump;

	assign cw = cpr_pkg::PROGRAM[pc_q];

	always_comb begin
		case (cw.cond)
			cpr_pkg::COND_IN_XFER:   jump = status.in_xfer;
			cpr_pkg::COND_LAST_EMIT: jump = status.emit_fire & status.last;
			default:                 jump = 1'b0;
		endcase
		pc_d = jump ? cw.target : pc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= cpr_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	assign ctrl.accept = cw.accept;
	assign ctrl.emit   = cw.emit;

endmodule

`default_nettype wire

// ----- hdl/cpr_datapath.sv -----
// Walk datapath: offsets, error term, run counter and the output register.
// Depends on cpr_pkg and the channel interfaces in cpr_channels.sv.
`default_nettype none

module cpr_datapath #(
	parameter int MAX_RADIUS = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cpr_pkg::ctrl_t ctrl,
	output cpr_pkg::status_t    status,
	cpr_req_if.sink             req,
	cpr_pt_if.source            pt
);

	localparam int E_W = cpr_pkg::E_W;

	logic signed [cpr_pkg::CX_W-1:0]  cx_q, cy_q;
	logic        [cpr_pkg::DX_W-1:0]  dx_q;
	logic signed [cpr_pkg::DY_W-1:0]  dy_q;
	logic signed [cpr_pkg::D_W-1:0]   d_q;
	logic        [cpr_pkg::CNT_W-1:0] cnt_q;
	logic                             out_valid_q;

	logic                             in_xfer, emit_fire, last;
	logic        [cpr_pkg::RAD_W-1:0] r_sat;
	logic signed [E_W-1:0]            dxw, dyw, dw, e1, e2, d_next, dy_next;
	logic                             move_h, move_v;

	assign in_xfer   = req.valid & ctrl.accept;
	assign emit_fire = ctrl.emit & (~out_valid_q | pt.ready);
	assign req.ready = ctrl.accept;

	assign r_sat = (req.radius > cpr_pkg::RAD_W'(MAX_RADIUS)) ?
		cpr_pkg::RAD_W'(MAX_RADIUS) : req.radius;

	assign dxw = $signed({{(E_W-cpr_pkg::DX_W){1'b0}}, dx_q});
	assign dyw = E_W'(dy_q);
	assign dw  = E_W'(d_q);

	// horizontal, vertical or diagonal move by the sign tests
	always_comb begin
		e1 = E_W'(2 * (dw + dyw) - 1);
		e2 = E_W'(2 * (dw - dxw) - 1);
		move_h = (dw < 0) && (e1 <= 0);
		move_v = !move_h && (dw > 0) && (e2 > 0);
		if (move_h) begin
			d_next  = E_W'(dw + 2 * dxw + 3);
			dy_next = dyw;
		end else if (move_v) begin
			d_next  = E_W'(dw + 3 - 2 * dyw);
			dy_next = E_W'(dyw - 1);
		end else begin
			d_next  = E_W'(dw + 2 * dxw - 2 * dyw + 2);
			dy_next = E_W'(dyw - 1);
		end
	end

	assign last = (dy_next < 0) || (cnt_q == cpr_pkg::RUN_LAST);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cx_q  <= req.center_x;
			cy_q  <= req.center_y;
			dx_q  <= '0;
			dy_q  <= $signed({1'b0, r_sat});
			d_q   <= cpr_pkg::D_W'(1 - 2 * $signed({1'b0, r_sat}));
			cnt_q <= '0;
		end else if (emit_fire) begin
			if (!move_v) begin
				dx_q <= dx_q + 1'b1;
			end
			dy_q  <= cpr_pkg::DY_W'(dy_next);
			d_q   <= cpr_pkg::D_W'(d_next);
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// output register, loaded with the group of the current walk position
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			pt.right_x   <= cpr_pkg::PT_W'(cx_q) + cpr_pkg::PT_W'(dxw);
			pt.left_x    <= cpr_pkg::PT_W'(cx_q) - cpr_pkg::PT_W'(dxw);
			pt.top_y     <= cpr_pkg::PT_W'(cy_q) + cpr_pkg::PT_W'(dyw);
			pt.bottom_y  <= cpr_pkg::PT_W'(cy_q) - cpr_pkg::PT_W'(dyw);
			pt.last_step <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (pt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign pt.valid = out_valid_q;

	assign status.in_xfer   = in_xfer;
	assign status.emit_fire = emit_fire;
	assign status.last      = last;

endmodule

`default_nettype wire
